>>> design/psafe_pkg.sv
// ----------------------------------------------------------------------------
// psafe_pkg
// Types, codes and constants shared by the pump safety timer blocks.
// ----------------------------------------------------------------------------
package psafe_pkg;

	// number of guarded pumps
	localparam int NUM_PUMPS = 2;
	// pumps visible on the result bit fields
	localparam int OUT_PUMPS = 2;
	localparam int OUT_BITS  = (NUM_PUMPS < OUT_PUMPS) ? NUM_PUMPS : OUT_PUMPS;

	// trips needed to enter system failsafe
	localparam int TRIPS_FOR_FAILSAFE = 2;

	// counter ceilings
	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
	localparam logic [18:0] SINCE_MAX   = 19'h7FFFF;
	localparam logic [5:0]  COUNT_MAX   = 6'h3F;

	// register reset values
	localparam logic [15:0] MAX_RUN_RST     = 16'd30000;
	localparam logic [18:0] COOLDOWN_RST    = 19'd300000;
	localparam logic [15:0] TRIP_RST        = 16'd60000;
	localparam logic [5:0]  COUNT_LIMIT_RST = 6'd20;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRIP        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 2'd3;

	// function codes
	localparam logic [2:0] FN_TICK     = 3'd0;
	localparam logic [2:0] FN_SENSOR   = 3'd1;
	localparam logic [2:0] FN_WATER    = 3'd2;
	localparam logic [2:0] FN_SOFTSTOP = 3'd3;
	localparam logic [2:0] FN_SHUTDOWN = 3'd4;
	localparam logic [2:0] FN_RESET_FS = 3'd5;

	// status codes
	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_STARTED  = 3'd1;
	localparam logic [2:0] ST_FAILSAFE = 3'd2;
	localparam logic [2:0] ST_ACTIVE   = 3'd3;
	localparam logic [2:0] ST_COOLDOWN = 3'd4;
	localparam logic [2:0] ST_COUNT    = 3'd5;
	localparam logic [2:0] ST_SENSOR   = 3'd6;

	typedef struct packed {
		logic [2:0]  func;
		logic        pump;
		logic [19:0] duration_ms;
		logic        sensor_valid;
	} psafe_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] pump_on;
		logic [1:0] pump_tripped;
		logic       failsafe_mode;
	} psafe_rsp_t;

	typedef struct packed {
		logic [15:0] max_run_ms;
		logic [18:0] cooldown_ms;
		logic [15:0] trip_ms;
		logic [5:0]  count_limit;
	} psafe_cfg_t;

endpackage

>>> design/pump_safety_timer_controller.sv
// ----------------------------------------------------------------------------
// pump_safety_timer_controller
// Safety timer for relay-driven pumps: start checks, run cap, trip, failsafe.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              word
//  req       in         req_valid / req_stall  psafe_req_t event word
//  rsp       out        rsp_valid / rsp_stall  psafe_rsp_t status word
//  cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one word per cycle while the result is not stalled; each word passes the
//  input register, then the single-pass update into the result register
//  the rate is set by the single-pass state update in psafe_core
//  reset clears all pump state and loads register defaults; no clearing pass
//  a stalled result holds and back-pressures the input register only
//  cfg_ready is always high
//
module pump_safety_timer_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  psafe_pkg::psafe_req_t             req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output psafe_pkg::psafe_rsp_t             rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [psafe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psafe_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import psafe_pkg::*;

	psafe_cfg_t cfg;
	psafe_req_t req_s1;
	logic       valid_s1;
	psafe_rsp_t rsp_next;
	psafe_rsp_t rsp_q;
	logic       rsp_valid_q;
	logic       adv;

	assign cfg_ready = 1'b1;

	// stage moves when the result register is free or being taken
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !adv;

	psafe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	psafe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && adv),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_next)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid)
			req_s1 <= req;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1)
			rsp_q <= rsp_next;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> design/psafe_cfg.sv
// ----------------------------------------------------------------------------
// psafe_cfg
// Configuration register file: run cap, cooldown, trip time, count limit.
// ----------------------------------------------------------------------------
module psafe_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [psafe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psafe_pkg::CFG_DATA_W-1:0] cfg_data,
	output psafe_pkg::psafe_cfg_t         cfg
);
	import psafe_pkg::*;

	psafe_cfg_t cfg_q;

	// register writes, index selects the target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_run_ms  <= MAX_RUN_RST;
			cfg_q.cooldown_ms <= COOLDOWN_RST;
			cfg_q.trip_ms     <= TRIP_RST;
			cfg_q.count_limit <= COUNT_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_RUN:     cfg_q.max_run_ms  <= cfg_data[15:0];
				REG_COOLDOWN:    cfg_q.cooldown_ms <= cfg_data[18:0];
				REG_TRIP:        cfg_q.trip_ms     <= cfg_data[15:0];
				REG_COUNT_LIMIT: cfg_q.count_limit <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/psafe_core.sv
// ----------------------------------------------------------------------------
// psafe_core
// Per-pump timer state and the single-pass update for one event word.
// ----------------------------------------------------------------------------
module psafe_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  psafe_pkg::psafe_req_t req,
	input  psafe_pkg::psafe_cfg_t cfg,
	output psafe_pkg::psafe_rsp_t rsp
);
	import psafe_pkg::*;

	logic [NUM_PUMPS-1:0] run_q, stop_q, trip_q, sensor_q;
	logic [NUM_PUMPS-1:0] run_d, stop_d, trip_d, sensor_d;
	logic [15:0] elap_q [NUM_PUMPS];
	logic [15:0] elap_d [NUM_PUMPS];
	logic [15:0] target_q [NUM_PUMPS];
	logic [15:0] target_d [NUM_PUMPS];
	logic [18:0] since_q [NUM_PUMPS];
	logic [18:0] since_d [NUM_PUMPS];
	logic [5:0]  cnt_q [NUM_PUMPS];
	logic [5:0]  cnt_d [NUM_PUMPS];
	logic        fs_q, fs_d;
	logic [2:0]  status;

	// next state, pumps handled in index order within a tick
	always_comb begin
		run_d    = run_q;
		stop_d   = stop_q;
		trip_d   = trip_q;
		sensor_d = sensor_q;
		elap_d   = elap_q;
		target_d = target_q;
		since_d  = since_q;
		cnt_d    = cnt_q;
		fs_d     = fs_q;
		status   = ST_DONE;
		case (req.func)
			FN_TICK: begin
				for (int i = 0; i < NUM_PUMPS; i++) begin
					if (since_d[i] < SINCE_MAX)
						since_d[i] = since_d[i] + 1'b1;
					if (run_d[i]) begin
						if (elap_d[i] < ELAPSED_MAX)
							elap_d[i] = elap_d[i] + 1'b1;
						if (elap_d[i] > cfg.trip_ms) begin
							// trip, maybe escalate to system failsafe
							run_d[i]  = 1'b0;
							trip_d[i] = 1'b1;
							stop_d[i] = 1'b1;
							if (($countones(trip_d) >= TRIPS_FOR_FAILSAFE) && !fs_d) begin
								fs_d   = 1'b1;
								stop_d = stop_d | run_d;
							end
						end else if (stop_d[i] || (elap_d[i] >= target_d[i])) begin
							run_d[i]   = 1'b0;
							since_d[i] = '0;
						end
					end
				end
			end
			FN_SENSOR: begin
				for (int i = 0; i < NUM_PUMPS; i++)
					if (i == int'(req.pump))
						sensor_d[i] = !req.sensor_valid;
			end
			FN_WATER: begin
				for (int i = 0; i < NUM_PUMPS; i++) begin
					if (i == int'(req.pump)) begin
						if (fs_q)
							status = ST_FAILSAFE;
						else if (run_q[i])
							status = ST_ACTIVE;
						else if (since_q[i] < cfg.cooldown_ms)
							status = ST_COOLDOWN;
						else if (cnt_q[i] > cfg.count_limit)
							status = ST_COUNT;
						else if (sensor_q[i])
							status = ST_SENSOR;
						else begin
							status      = ST_STARTED;
							run_d[i]    = 1'b1;
							elap_d[i]   = '0;
							stop_d[i]   = 1'b0;
							trip_d[i]   = 1'b0;
							target_d[i] = (req.duration_ms < {4'b0, cfg.max_run_ms}) ?
								req.duration_ms[15:0] : cfg.max_run_ms;
							if (cnt_q[i] < COUNT_MAX)
								cnt_d[i] = cnt_q[i] + 1'b1;
						end
					end
				end
			end
			FN_SOFTSTOP: begin
				stop_d = stop_q | run_q;
			end
			FN_SHUTDOWN: begin
				// nothing left running, so entering failsafe adds no stops
				run_d  = '0;
				stop_d = '1;
				fs_d   = 1'b1;
			end
			FN_RESET_FS: begin
				fs_d = 1'b0;
			end
			default: ;
		endcase
	end

	// state registers, updated once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= '0;
			stop_q   <= '0;
			trip_q   <= '0;
			sensor_q <= '0;
			fs_q     <= 1'b0;
			for (int i = 0; i < NUM_PUMPS; i++) begin
				elap_q[i]   <= '0;
				target_q[i] <= '0;
				since_q[i]  <= '0;
				cnt_q[i]    <= '0;
			end
		end else if (fire) begin
			run_q    <= run_d;
			stop_q   <= stop_d;
			trip_q   <= trip_d;
			sensor_q <= sensor_d;
			fs_q     <= fs_d;
			elap_q   <= elap_d;
			target_q <= target_d;
			since_q  <= since_d;
			cnt_q    <= cnt_d;
		end
	end

	// result word from the updated state
	always_comb begin
		rsp               = '0;
		rsp.status        = status;
		rsp.failsafe_mode = fs_d;
		for (int i = 0; i < OUT_BITS; i++) begin
			rsp.pump_on[i]      = run_d[i];
			rsp.pump_tripped[i] = trip_d[i];
		end
	end

endmodule

>>> design/psafe_checker.sv
// ----------------------------------------------------------------------------
// psafe_checker
// Port-level checks on the pump safety timer result channel.
// ----------------------------------------------------------------------------
module psafe_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_stall,
	input psafe_pkg::psafe_rsp_t rsp
);
	import psafe_pkg::*;

	// a started pump never happens in failsafe mode
	a_start_not_failsafe: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_STARTED) |-> !rsp.failsafe_mode)
		else $error("pump started while in failsafe mode");

	// a running pump is never flagged tripped
	a_on_not_tripped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.pump_on & rsp.pump_tripped) == 2'b00))
		else $error("pump both on and tripped");

	// a start reports at least one pump on
	a_start_pump_on: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_STARTED) |-> (rsp.pump_on != 2'b00))
		else $error("start reported with no pump on");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule

bind pump_safety_timer_controller psafe_checker u_psafe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
